// ----- rtl/core/prl_pkg.sv -----
// Shared constants, item types and sequencer states of the polygon region locator.
package prl_pkg;

   localparam int CoordW   = 24;
   localparam int RegionN  = 16;
   localparam int VertexN  = 16;
   localparam int RegionW  = $clog2(RegionN);
   localparam int VertexW  = $clog2(VertexN);
   localparam int VcntW    = $clog2(VertexN + 1);
   localparam int RcntW    = $clog2(RegionN + 1);
   localparam int AddrW    = RegionW + VertexW;
   localparam int DiffW    = CoordW + 1;
   localparam int OpW      = 2 * DiffW + 2;
   localparam int HalfW    = OpW / 2;
   localparam int ProdW    = 2 * OpW;
   localparam int TolW     = 16;
   localparam int FbDistW  = 24;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   localparam logic [1:0] ReqVertex = 2'd0;
   localparam logic [1:0] ReqRegion = 2'd1;
   localparam logic [1:0] ReqQuery  = 2'd2;

   localparam logic [1:0] MatchInside   = 2'd0;
   localparam logic [1:0] MatchBoundary = 2'd1;
   localparam logic [1:0] MatchFallback = 2'd2;
   localparam logic [1:0] MatchNone     = 2'd3;

   localparam logic [1:0] CsrRegionCount = 2'd0;
   localparam logic [1:0] CsrTolerance   = 2'd1;
   localparam logic [1:0] CsrFbEnable    = 2'd2;
   localparam logic [1:0] CsrFbDistance  = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [RegionW-1:0]       region_index;
      logic [VertexW-1:0]       vertex_index;
      logic [VcntW-1:0]         vertex_count;
      logic signed [CoordW-1:0] x_mm;
      logic signed [CoordW-1:0] y_mm;
   } req_item_type;

   typedef struct packed {
      logic               found;
      logic [RegionW-1:0] region_found;
      logic [1:0]         match_kind;
   } rsp_item_type;

   typedef struct packed {
      logic [RcntW-1:0]   region_count;
      logic [TolW-1:0]    tolerance;
      logic               fb_enable;
      logic [FbDistW-1:0] fb_distance;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
   } point_type;

   typedef struct packed {
      logic               vtx_we;
      logic               rgn_we;
      logic               rd_en;
      logic [AddrW-1:0]   rd_addr;
      logic [RegionW-1:0] region;
   } store_ctl_type;

   typedef struct packed {
      logic                  go;
      logic signed [OpW-1:0] a;
      logic signed [OpW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ProdW-1:0] prod;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TOL, ST_REG, ST_CDX, ST_CDY, ST_VPRE, ST_VPREL, ST_VRD, ST_VLD,
      ST_EIN, ST_EIN2, ST_EB, ST_EC1A, ST_EC1B, ST_ECHK, ST_EQA, ST_EQB, ST_EC2A,
      ST_EC2B, ST_ECHK2, ST_ECRA, ST_ECRB, ST_ELHS, ST_ERHS, ST_ENXT, ST_REND,
      ST_FB, ST_FBM, ST_OUT
   } state_type;

endpackage

// ----- rtl/core/polygon_region_locator.sv -----
// Top level of the polygon region locator: register port, region table, sequencer, multiplier.
//
// Load items (vertex writes, region vertex count and centroid) are taken when start
// is high and busy is low; they give no result and busy stays low.
// A query item raises busy until its single result is shown: rsp_strobe is high for
// exactly one cycle with rsp_item, and busy drops in the cycle after.
// Every product goes through one shared multiplier that builds each product from
// four half-width partial products. Each region costs two products for its centroid
// distance, and each edge up to 2 products for the crossing test and 0, 4, 6 or 8
// for the boundary test, besides its vertex reads and dispatch states; a query
// takes one more product when the fallback distance is checked.
// Reset clears the sequencer, the configuration registers and all region vertex
// counts; vertex and centroid entries hold whatever was last written.
// The receiver cannot stall: a result is taken in the cycle it is strobed.
// Configuration registers are written through the APB-style port; the user must write
// them only while busy is low, as the block itself does not enforce it.
module polygon_region_locator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prl_pkg::CsrAddrW-1:0]  paddr,
   input  logic [prl_pkg::CsrDataW-1:0]  pwdata,
   output logic [prl_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready,
   input  logic                          start,
   output logic                          busy,
   input  prl_pkg::req_item_type         req_item,
   output logic                          rsp_strobe,
   output prl_pkg::rsp_item_type         rsp_item
);
   import prl_pkg::*;

   cfg_type          cfg;
   store_ctl_type    ctl;
   point_type        vtx_rd;
   point_type        centroid;
   logic [VcntW-1:0] n;
   mul_req_type      mreq;
   mul_rsp_type      mrsp;

   prl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   prl_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .wr_item  (req_item),
      .vtx_rd   (vtx_rd),
      .n        (n),
      .centroid (centroid)
   );

   prl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   prl_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .cfg        (cfg),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .ctl        (ctl),
      .vtx_rd     (vtx_rd),
      .n          (n),
      .centroid   (centroid),
      .mreq       (mreq),
      .mrsp       (mrsp)
   );

endmodule

// ----- rtl/core/prl_csr.sv -----
// Configuration registers behind the APB-style port.
module prl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prl_pkg::CsrAddrW-1:0]  paddr,
   input  logic [prl_pkg::CsrDataW-1:0]  pwdata,
   output logic [prl_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready,
   output prl_pkg::cfg_type              cfg
);
   import prl_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite & pready;
   assign idx    = paddr[3:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            CsrRegionCount: cfg_in.region_count = pwdata[RcntW-1:0];
            CsrTolerance:   cfg_in.tolerance    = pwdata[TolW-1:0];
            CsrFbEnable:    cfg_in.fb_enable    = pwdata[0];
            CsrFbDistance:  cfg_in.fb_distance  = pwdata[FbDistW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CsrRegionCount: prdata = CsrDataW'(cfg_ff.region_count);
         CsrTolerance:   prdata = CsrDataW'(cfg_ff.tolerance);
         CsrFbEnable:    prdata = CsrDataW'(cfg_ff.fb_enable);
         CsrFbDistance:  prdata = CsrDataW'(cfg_ff.fb_distance);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/prl_mul.sv -----
// Shared signed multiplier: four half-width partial products, accumulated one after another.
module prl_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  prl_pkg::mul_req_type req,
   output prl_pkg::mul_rsp_type rsp
);
   import prl_pkg::*;

   logic [OpW-1:0]       ma_ff, ma_in, mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [2:0]           k_ff, k_in;
   logic [1:0]           sh_ff, sh_in;
   logic [2*HalfW-1:0]   pp_ff, pp_in;
   logic [ProdW-1:0]     acc_ff, acc_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [OpW-1:0]       abs_a, abs_b;
   logic [HalfW-1:0]     ha, hb;

   assign abs_a = req.a[OpW-1] ? OpW'(-req.a) : OpW'(req.a);
   assign abs_b = req.b[OpW-1] ? OpW'(-req.b) : OpW'(req.b);
   assign ha    = k_ff[1] ? ma_ff[OpW-1:HalfW] : ma_ff[HalfW-1:0];
   assign hb    = k_ff[0] ? mb_ff[OpW-1:HalfW] : mb_ff[HalfW-1:0];
   assign rsp.done = done_ff;
   assign rsp.prod = prod_ff;

   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      sh_in   = {1'b0, k_ff[1]} + {1'b0, k_ff[0]};
      pp_in   = ha * hb;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (req.go) begin
         ma_in  = abs_a;
         mb_in  = abs_b;
         neg_in = req.a[OpW-1] ^ req.b[OpW-1];
         acc_in = '0;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         k_in = k_ff + 3'd1;
         if (k_ff >= 3'd1 && k_ff <= 3'd4) begin
            acc_in = acc_ff + (ProdW'(pp_ff) << (HalfW * int'(sh_ff)));
         end
         if (k_ff == 3'd5) begin
            prod_in = neg_ff ? -acc_ff : acc_ff;
            done_in = 1'b1;
            run_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      sh_ff   <= sh_in;
      pp_ff   <= pp_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/core/prl_store.sv -----
// Region table: vertex memory, per-region vertex counts and centroids.
module prl_store (
   input  logic                          clock,
   input  logic                          reset,
   input  prl_pkg::store_ctl_type        ctl,
   input  prl_pkg::req_item_type         wr_item,
   output prl_pkg::point_type            vtx_rd,
   output logic [prl_pkg::VcntW-1:0]     n,
   output prl_pkg::point_type            centroid
);
   import prl_pkg::*;

   point_type          vtx_mem [RegionN*VertexN];
   point_type          vtx_rd_ff;
   logic [VcntW-1:0]   count_ff [RegionN];
   point_type          centroid_ff [RegionN];
   logic [VcntW-1:0]   count_sat;

   assign count_sat = (wr_item.vertex_count > VcntW'(VertexN)) ? VcntW'(VertexN)
                                                                : wr_item.vertex_count;
   assign vtx_rd   = vtx_rd_ff;
   assign n        = count_ff[ctl.region];
   assign centroid = centroid_ff[ctl.region];

   always_ff @(posedge clock) begin
      if (ctl.vtx_we) begin
         vtx_mem[{wr_item.region_index, wr_item.vertex_index}] <= {wr_item.x_mm, wr_item.y_mm};
      end
      if (ctl.rd_en) begin
         vtx_rd_ff <= vtx_mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '{default: '0};
      end else if (ctl.rgn_we) begin
         count_ff[wr_item.region_index] <= count_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rgn_we) begin
         centroid_ff[wr_item.region_index] <= {wr_item.x_mm, wr_item.y_mm};
      end
   end

endmodule

// ----- rtl/core/prl_seq.sv -----
// Query sequencer: dispatches load items, walks regions and edges, drives the shared multiplier, picks the region.
module prl_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  prl_pkg::req_item_type      req_item,
   input  prl_pkg::cfg_type           cfg,
   output logic                       busy,
   output logic                       rsp_strobe,
   output prl_pkg::rsp_item_type      rsp_item,
   output prl_pkg::store_ctl_type     ctl,
   input  prl_pkg::point_type         vtx_rd,
   input  logic [prl_pkg::VcntW-1:0]  n,
   input  prl_pkg::point_type         centroid,
   output prl_pkg::mul_req_type       mreq,
   input  prl_pkg::mul_rsp_type       mrsp
);
   import prl_pkg::*;

   state_type state_ff, state_in;

   logic                    pend_ff, pend_in;
   logic signed [CoordW-1:0] px_ff, px_in, py_ff, py_in;
   logic [2*TolW-1:0]       t2_ff, t2_in;
   logic [RcntW-1:0]        r_ff, r_in;
   logic [VertexW-1:0]      i_ff, i_in;
   point_type               prev_ff, prev_in, cur_ff, cur_in;
   logic signed [DiffW-1:0] vx_ff, vx_in, vy_ff, vy_in, wx_ff, wx_in, wy_ff, wy_in;
   logic signed [DiffW-1:0] ux_ff, ux_in, uy_ff, uy_in;
   logic                    cross_ff, cross_in, inside_ff, inside_in, near_ff, near_in;
   logic                    qsel_ff, qsel_in;
   logic signed [ProdW-1:0] s_ff, s_in;
   logic signed [OpW-1:0]   c1_ff, c1_in, c2_ff, c2_in, cr_ff, cr_in;
   logic signed [OpW-1:0]   d_ff, d_in, in_d_ff, in_d_in, bd_d_ff, bd_d_in, fd_ff, fd_in;
   logic                    in_any_ff, in_any_in, bd_any_ff, bd_any_in, fb_any_ff, fb_any_in;
   logic [RegionW-1:0]      in_idx_ff, in_idx_in, bd_idx_ff, bd_idx_in, fb_idx_ff, fb_idx_in;
   rsp_item_type            res_ff, res_in;

   logic                    use_mul, mul_ev;
   logic [RcntW-1:0]        qcount;
   logic [RegionW-1:0]      r_idx;
   logic signed [OpW-1:0]   cdx, cdy;
   logic signed [ProdW-1:0] t2_ext, qsum;

   assign qcount = (cfg.region_count > RcntW'(RegionN)) ? RcntW'(RegionN) : cfg.region_count;
   assign r_idx  = r_ff[RegionW-1:0];
   assign cdx    = OpW'(px_ff) - OpW'(centroid.x);
   assign cdy    = OpW'(py_ff) - OpW'(centroid.y);
   assign t2_ext = ProdW'(t2_ff);
   assign qsum   = s_ff + mrsp.prod;
   assign mul_ev = pend_ff & mrsp.done;
   assign busy   = (state_ff != ST_IDLE);
   assign rsp_item = res_ff;

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      px_in = px_ff;  py_in = py_ff;  t2_in = t2_ff;  r_in = r_ff;  i_in = i_ff;
      prev_in = prev_ff;  cur_in = cur_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  wx_in = wx_ff;  wy_in = wy_ff;
      ux_in = ux_ff;  uy_in = uy_ff;
      cross_in = cross_ff;  inside_in = inside_ff;  near_in = near_ff;  qsel_in = qsel_ff;
      s_in = s_ff;  c1_in = c1_ff;  c2_in = c2_ff;  cr_in = cr_ff;
      d_in = d_ff;  in_d_in = in_d_ff;  bd_d_in = bd_d_ff;  fd_in = fd_ff;
      in_any_in = in_any_ff;  bd_any_in = bd_any_ff;  fb_any_in = fb_any_ff;
      in_idx_in = in_idx_ff;  bd_idx_in = bd_idx_ff;  fb_idx_in = fb_idx_ff;
      res_in = res_ff;
      use_mul    = 1'b0;
      rsp_strobe = 1'b0;
      mreq       = '0;
      ctl        = '0;
      ctl.region = r_idx;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.req_type)
                  ReqVertex: ctl.vtx_we = 1'b1;
                  ReqRegion: ctl.rgn_we = 1'b1;
                  ReqQuery: begin
                     px_in = req_item.x_mm;
                     py_in = req_item.y_mm;
                     r_in  = '0;
                     in_any_in = 1'b0;
                     bd_any_in = 1'b0;
                     fb_any_in = 1'b0;
                     state_in  = ST_TOL;
                  end
                  default: ;
               endcase
            end
         end
         ST_TOL: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(cfg.tolerance);
            mreq.b  = OpW'(cfg.tolerance);
            if (mul_ev) begin
               t2_in    = mrsp.prod[2*TolW-1:0];
               state_in = ST_REG;
            end
         end
         ST_REG: begin
            state_in = (r_ff == qcount) ? ST_FB : ST_CDX;
         end
         ST_CDX: begin
            use_mul = 1'b1;
            mreq.a  = cdx;
            mreq.b  = cdx;
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_CDY;
            end
         end
         ST_CDY: begin
            use_mul = 1'b1;
            mreq.a  = cdy;
            mreq.b  = cdy;
            if (mul_ev) begin
               d_in     = OpW'(qsum);
               state_in = ST_VPRE;
            end
         end
         ST_VPRE: begin
            if (!fb_any_ff || d_ff < fd_ff) begin
               fb_any_in = 1'b1;
               fb_idx_in = r_idx;
               fd_in     = d_ff;
            end
            inside_in = 1'b0;
            near_in   = 1'b0;
            if (n == '0) begin
               state_in = ST_REND;
            end else begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = {r_idx, VertexW'(n - VcntW'(1))};
               state_in    = ST_VPREL;
            end
         end
         ST_VPREL: begin
            prev_in  = vtx_rd;
            i_in     = '0;
            state_in = ST_VRD;
         end
         ST_VRD: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = {r_idx, i_ff};
            state_in    = ST_VLD;
         end
         ST_VLD: begin
            cur_in   = vtx_rd;
            vx_in    = DiffW'(vtx_rd.x) - DiffW'(prev_ff.x);
            vy_in    = DiffW'(vtx_rd.y) - DiffW'(prev_ff.y);
            wx_in    = DiffW'(px_ff) - DiffW'(prev_ff.x);
            wy_in    = DiffW'(py_ff) - DiffW'(prev_ff.y);
            ux_in    = DiffW'(px_ff) - DiffW'(vtx_rd.x);
            uy_in    = DiffW'(py_ff) - DiffW'(vtx_rd.y);
            cross_in = (vtx_rd.y > py_ff) != (prev_ff.y > py_ff);
            state_in = ST_EIN;
         end
         ST_EIN: begin
            if (!cross_ff) begin
               state_in = ST_EB;
            end else begin
               use_mul = 1'b1;
               mreq.a  = OpW'(ux_ff);
               mreq.b  = OpW'(vy_ff);
               if (mul_ev) begin
                  s_in     = mrsp.prod;
                  state_in = ST_EIN2;
               end
            end
         end
         ST_EIN2: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vx_ff);
            mreq.b  = OpW'(uy_ff);
            if (mul_ev) begin
               if (vy_ff < 0 ? (s_ff > mrsp.prod) : (s_ff < mrsp.prod)) begin
                  inside_in = !inside_ff;
               end
               state_in = ST_EB;
            end
         end
         ST_EB: begin
            state_in = near_ff ? ST_ENXT : ST_EC1A;
         end
         ST_EC1A: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vx_ff);
            mreq.b  = OpW'(wx_ff);
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_EC1B;
            end
         end
         ST_EC1B: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vy_ff);
            mreq.b  = OpW'(wy_ff);
            if (mul_ev) begin
               c1_in    = OpW'(qsum);
               state_in = ST_ECHK;
            end
         end
         ST_ECHK: begin
            if (c1_ff <= 0) begin
               qsel_in  = 1'b0;
               state_in = ST_EQA;
            end else begin
               state_in = ST_EC2A;
            end
         end
         ST_EQA: begin
            use_mul = 1'b1;
            mreq.a  = qsel_ff ? OpW'(ux_ff) : OpW'(wx_ff);
            mreq.b  = mreq.a;
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_EQB;
            end
         end
         ST_EQB: begin
            use_mul = 1'b1;
            mreq.a  = qsel_ff ? OpW'(uy_ff) : OpW'(wy_ff);
            mreq.b  = mreq.a;
            if (mul_ev) begin
               if (qsum <= t2_ext) begin
                  near_in = 1'b1;
               end
               state_in = ST_ENXT;
            end
         end
         ST_EC2A: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vx_ff);
            mreq.b  = OpW'(vx_ff);
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_EC2B;
            end
         end
         ST_EC2B: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vy_ff);
            mreq.b  = OpW'(vy_ff);
            if (mul_ev) begin
               c2_in    = OpW'(qsum);
               state_in = ST_ECHK2;
            end
         end
         ST_ECHK2: begin
            if (c2_ff <= c1_ff) begin
               qsel_in  = 1'b1;
               state_in = ST_EQA;
            end else begin
               state_in = ST_ECRA;
            end
         end
         ST_ECRA: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vx_ff);
            mreq.b  = OpW'(wy_ff);
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_ECRB;
            end
         end
         ST_ECRB: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(vy_ff);
            mreq.b  = OpW'(wx_ff);
            if (mul_ev) begin
               cr_in    = OpW'(s_ff - mrsp.prod);
               state_in = ST_ELHS;
            end
         end
         ST_ELHS: begin
            use_mul = 1'b1;
            mreq.a  = cr_ff;
            mreq.b  = cr_ff;
            if (mul_ev) begin
               s_in     = mrsp.prod;
               state_in = ST_ERHS;
            end
         end
         ST_ERHS: begin
            use_mul = 1'b1;
            mreq.a  = c2_ff;
            mreq.b  = OpW'(t2_ff);
            if (mul_ev) begin
               if (s_ff <= mrsp.prod) begin
                  near_in = 1'b1;
               end
               state_in = ST_ENXT;
            end
         end
         ST_ENXT: begin
            prev_in = cur_ff;
            if (VcntW'(i_ff) == n - VcntW'(1)) begin
               state_in = ST_REND;
            end else begin
               i_in     = i_ff + VertexW'(1);
               state_in = ST_VRD;
            end
         end
         ST_REND: begin
            if (inside_ff) begin
               if (!in_any_ff || d_ff < in_d_ff) begin
                  in_any_in = 1'b1;
                  in_idx_in = r_idx;
                  in_d_in   = d_ff;
               end
            end else if (near_ff) begin
               if (!bd_any_ff || d_ff < bd_d_ff) begin
                  bd_any_in = 1'b1;
                  bd_idx_in = r_idx;
                  bd_d_in   = d_ff;
               end
            end
            r_in     = r_ff + RcntW'(1);
            state_in = ST_REG;
         end
         ST_FB: begin
            res_in.found        = 1'b0;
            res_in.region_found = '0;
            res_in.match_kind   = MatchNone;
            state_in            = ST_OUT;
            if (in_any_ff) begin
               res_in.found        = 1'b1;
               res_in.region_found = in_idx_ff;
               res_in.match_kind   = MatchInside;
            end else if (bd_any_ff) begin
               res_in.found        = 1'b1;
               res_in.region_found = bd_idx_ff;
               res_in.match_kind   = MatchBoundary;
            end else if (cfg.fb_enable && qcount != '0) begin
               state_in = ST_FBM;
            end
         end
         ST_FBM: begin
            use_mul = 1'b1;
            mreq.a  = OpW'(cfg.fb_distance);
            mreq.b  = OpW'(cfg.fb_distance);
            if (mul_ev) begin
               if (fd_ff <= mrsp.prod) begin
                  res_in.found        = 1'b1;
                  res_in.region_found = fb_idx_ff;
                  res_in.match_kind   = MatchFallback;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (use_mul) begin
         mreq.go = !pend_ff;
         pend_in = pend_ff ? !mrsp.done : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;  py_ff <= py_in;  t2_ff <= t2_in;  r_ff <= r_in;  i_ff <= i_in;
      prev_ff <= prev_in;  cur_ff <= cur_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;  wx_ff <= wx_in;  wy_ff <= wy_in;
      ux_ff <= ux_in;  uy_ff <= uy_in;
      cross_ff <= cross_in;  inside_ff <= inside_in;  near_ff <= near_in;  qsel_ff <= qsel_in;
      s_ff <= s_in;  c1_ff <= c1_in;  c2_ff <= c2_in;  cr_ff <= cr_in;
      d_ff <= d_in;  in_d_ff <= in_d_in;  bd_d_ff <= bd_d_in;  fd_ff <= fd_in;
      in_any_ff <= in_any_in;  bd_any_ff <= bd_any_in;  fb_any_ff <= fb_any_in;
      in_idx_ff <= in_idx_in;  bd_idx_ff <= bd_idx_in;  fb_idx_ff <= fb_idx_in;
      res_ff <= res_in;
   end

endmodule
